[rtl/ih_pkg.sv]
// ih_pkg: types and constants for the IPv4 header check block.
// Used by the result interface ih_result_if and by ipv4_header_check.
package ih_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned IdxW        = 5;

  localparam logic [IdxW-1:0] VersionPos = IdxW'(0);
  localparam logic [IdxW-1:0] ProtoPos   = IdxW'(9);
  localparam logic [IdxW-1:0] CsumHiPos  = IdxW'(10);
  localparam logic [IdxW-1:0] CsumLoPos  = IdxW'(11);
  localparam logic [IdxW-1:0] LastPos    = IdxW'(HeaderBytes - 1);

  localparam logic [15:0] SumStart = 16'hffff;

  localparam logic [1:0] CfgVersion  = 2'd0;
  localparam logic [1:0] CfgFirstPr  = 2'd1;
  localparam logic [1:0] CfgSecondPr = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_BAD_CSUM    = 2'd2,
    ST_BAD_PROTO   = 2'd3
  } status_e;

endpackage

[rtl/ih_if.sv]
// ih_byte_if and ih_result_if: valid/ready channels for header bytes and results.
// Depends on ih_pkg for the status type.
interface ih_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;

  modport source (output valid, output header_byte, input ready);
  modport sink   (input valid, input header_byte, output ready);
endinterface

interface ih_result_if
  import ih_pkg::*;
;
  logic       valid;
  logic       ready;
  status_e    status;
  logic       route;
  logic [7:0] protocol;

  modport source (output valid, output status, output route, output protocol, input ready);
  modport sink   (input valid, input status, input route, input protocol, output ready);
endinterface

[rtl/ipv4_header_check.sv]
// ipv4_header_check: checks IPv4 header bytes, one per beat, and gives one result per header.
// Depends on ih_pkg and the channel interfaces in ih_if.sv.
//
// One header byte is taken per cycle, back to back, unless stalled; each byte is held in
// an input register and is then folded into the 16-bit ones' complement sum by a single
// add with end-around carry. A header's result is registered in the output register as its
// last byte leaves the input register, so a stream of headers runs at one byte per cycle.
// The only stall is the last byte of a header waiting while the output register still
// holds an untaken result. Configuration is written through cfg_we_i/cfg_idx_i.
module ipv4_header_check
  import ih_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  ih_byte_if.sink     in_byte,
  ih_result_if.source out_res
);

  logic [7:0] ver_byte_q, first_pr_q, second_pr_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      high_q, high_d;
  logic            ver_good_q, ver_good_d;
  logic [15:0]     rx_sum_q, rx_sum_d;
  logic [7:0]      proto_q, proto_d;

  logic       out_valid_q;
  status_e    status_q, status_d;
  logic       route_q, route_d;
  logic [7:0] out_proto_q;

  logic            out_free, is_last, advance;
  logic [IdxW-1:0] idx;
  logic [7:0]      eff;
  logic [15:0]     word, folded;
  logic            add_en;
  logic [16:0]     acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_byte_q  <= 8'd69;
      first_pr_q  <= 8'd1;
      second_pr_q <= 8'd17;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVersion:  ver_byte_q  <= cfg_data_i;
        CfgFirstPr:  first_pr_q  <= cfg_data_i;
        CfgSecondPr: second_pr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid_q || out_res.ready;
  assign idx          = (idx_q > LastPos) ? VersionPos : idx_q;
  assign is_last      = (idx == LastPos);
  assign advance      = in_valid_q && (!is_last || out_free);
  assign in_byte.ready = !in_valid_q || advance;

  always_comb begin
    eff        = ((idx == CsumHiPos) || (idx == CsumLoPos)) ? 8'd0 : in_byte_q;
    ver_good_d = (idx == VersionPos) ? (in_byte_q == ver_byte_q) : ver_good_q;
    proto_d    = (idx == ProtoPos) ? in_byte_q : proto_q;
    rx_sum_d   = rx_sum_q;
    if (idx == CsumHiPos) begin
      rx_sum_d[15:8] = in_byte_q;
    end
    if (idx == CsumLoPos) begin
      rx_sum_d[7:0] = in_byte_q;
    end
    high_d = high_q;
    add_en = 1'b0;
    word   = 16'd0;
    if (!idx[0]) begin
      high_d = eff;
      add_en = is_last;
      word   = {eff, 8'd0};
    end else begin
      add_en = 1'b1;
      word   = {high_q, eff};
    end
    acc    = {1'b0, sum_q} + {1'b0, word};
    folded = acc[16] ? (acc[15:0] + 16'd1) : acc[15:0];
    sum_d  = add_en ? folded : sum_q;
    idx_d  = is_last ? VersionPos : IdxW'(idx + IdxW'(1));

    route_d = 1'b0;
    priority if (!ver_good_d) begin
      status_d = ST_BAD_VERSION;
    end else if (rx_sum_d != ~sum_d) begin
      status_d = ST_BAD_CSUM;
    end else if (proto_d == first_pr_q) begin
      status_d = ST_ACCEPTED;
    end else if (proto_d == second_pr_q) begin
      status_d = ST_ACCEPTED;
      route_d  = 1'b1;
    end else begin
      status_d = ST_BAD_PROTO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      idx_q       <= VersionPos;
      sum_q       <= SumStart;
      high_q      <= 8'd0;
      ver_good_q  <= 1'b0;
      rx_sum_q    <= 16'd0;
      proto_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_byte.ready) begin
        in_valid_q <= in_byte.valid;
      end
      if (advance) begin
        idx_q      <= idx_d;
        sum_q      <= is_last ? SumStart : sum_d;
        high_q     <= high_d;
        ver_good_q <= ver_good_d;
        rx_sum_q   <= rx_sum_d;
        proto_q    <= proto_d;
      end
      if (advance && is_last) begin
        out_valid_q <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_byte.ready && in_byte.valid) begin
      in_byte_q <= in_byte.header_byte;
    end
    if (advance && is_last) begin
      status_q    <= status_d;
      route_q     <= route_d;
      out_proto_q <= proto_d;
    end
  end

  assign out_res.valid    = out_valid_q;
  assign out_res.status   = status_q;
  assign out_res.route    = route_q;
  assign out_res.protocol = out_proto_q;

endmodule

[verif/ipv4_header_check_test.sv]
`timescale 1ns / 1ps
// ipv4_header_check_test: self-checking bench for ipv4_header_check, fed whole 20-byte headers.
// Predicts results with its checksum model or takes probes' given ones; needs ih_pkg, ih_if.sv.
module ipv4_header_check_test
  import ih_pkg::*;
;

  localparam logic [1:0] CfgUnused = 2'd3;

  typedef logic [7:0] header_t [HeaderBytes];

  typedef struct packed {
    status_e    status;
    logic       route;
    logic [7:0] protocol;
  } verdict_t;

  typedef struct packed {
    logic     given;
    verdict_t v;
  } spelled_t;

  typedef struct {
    logic [7:0]  cfg_vl;
    logic [7:0]  cfg_p1;
    logic [7:0]  cfg_p2;
    logic [7:0]  vl;
    logic [7:0]  proto;
    logic [7:0]  fill;
    logic [15:0] flip;
    logic        known;
    status_e     status;
    logic        route;
  } probe_t;

  typedef enum int {
    FR_CLEAN,
    FR_BAD_VERSION,
    FR_BAD_CSUM,
    FR_ODD_PROTO,
    FR_NOISE
  } frame_kind_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;

  ih_byte_if   byte_ch ();
  ih_result_if res_ch ();

  ipv4_header_check DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_byte    (byte_ch),
    .out_res    (res_ch)
  );

  // model state and register copies
  logic [4:0]  byte_pos     = '0;
  logic [15:0] run_sum      = SumStart;
  logic [7:0]  high_byte    = '0;
  logic        version_ok   = 1'b0;
  logic [15:0] csum_field   = '0;
  logic [7:0]  proto_byte   = '0;
  logic [7:0]  want_vl      = 8'd69;
  logic [7:0]  route0_proto = 8'd1;
  logic [7:0]  route1_proto = 8'd17;

  verdict_t verdict_q [$];
  spelled_t spelled_q [$];
  header_t  frame;
  int       gap_pct = 26;
  int       errors  = 0;

  probe_t probes [9] = '{
    '{8'd69,  8'd1,   8'd17, 8'h45, 8'd1,   8'h00, 16'h0000, 1'b1, ST_ACCEPTED,    1'b0},
    '{8'd69,  8'd1,   8'd17, 8'h45, 8'd17,  8'hff, 16'h0000, 1'b1, ST_ACCEPTED,    1'b1},
    '{8'd69,  8'd1,   8'd17, 8'h46, 8'd1,   8'ha5, 16'h0000, 1'b1, ST_BAD_VERSION, 1'b0},
    '{8'd69,  8'd1,   8'd17, 8'h00, 8'd6,   8'h00, 16'h8001, 1'b1, ST_BAD_VERSION, 1'b0},
    '{8'd69,  8'd1,   8'd17, 8'h45, 8'd6,   8'h5a, 16'hffff, 1'b1, ST_BAD_CSUM,    1'b0},
    '{8'd69,  8'd1,   8'd17, 8'h45, 8'd6,   8'h3c, 16'h0000, 1'b1, ST_BAD_PROTO,   1'b0},
    '{8'd69,  8'd6,   8'd6,  8'h45, 8'd6,   8'hc3, 16'h0000, 1'b1, ST_ACCEPTED,    1'b0},
    '{8'd0,   8'd0,   8'd255, 8'h00, 8'd255, 8'hff, 16'h0000, 1'b1, ST_ACCEPTED,   1'b1},
    '{8'd255, 8'd255, 8'd0,  8'hff, 8'd0,   8'h96, 16'h0000, 1'b0, ST_ACCEPTED,    1'b0}
  };

  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    if (s > 17'h0ffff) s = s - 17'h0ffff;
    return s[15:0];
  endfunction

  function automatic logic [15:0] header_csum(input header_t h);
    logic [15:0] acc;
    acc = SumStart;
    for (int i = 0; i < HeaderBytes; i += 2)
      acc = fold_add(acc, (i == CsumHiPos) ? 16'h0000 : {h[i], h[i+1]});
    return ~acc;
  endfunction

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= gap_pct);
  end

  // fold accepted beats into the model, then check results against the oldest verdict
  always @(posedge clk_i) begin
    logic [4:0] at;
    logic [7:0] b;
    logic [7:0] kept;
    verdict_t   want;
    spelled_t   spelled;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      b  = byte_ch.header_byte;
      at = (byte_pos >= HeaderBytes) ? VersionPos : byte_pos;
      if (at == VersionPos) version_ok = (b == want_vl);
      if (at == ProtoPos) proto_byte = b;
      if (at == CsumHiPos) csum_field[15:8] = b;
      if (at == CsumLoPos) csum_field[7:0] = b;
      kept = (at == CsumHiPos || at == CsumLoPos) ? 8'h00 : b;
      if (!at[0]) begin
        high_byte = kept;
        if (at == LastPos) run_sum = fold_add(run_sum, {kept, 8'h00});
      end else begin
        run_sum = fold_add(run_sum, {high_byte, kept});
      end
      if (at == LastPos) begin
        want.protocol = proto_byte;
        want.route    = 1'b0;
        if (!version_ok) begin
          want.status = ST_BAD_VERSION;
        end else if (csum_field != ~run_sum) begin
          want.status = ST_BAD_CSUM;
        end else if (proto_byte == route0_proto) begin
          want.status = ST_ACCEPTED;
        end else if (proto_byte == route1_proto) begin
          want.status = ST_ACCEPTED;
          want.route  = 1'b1;
        end else begin
          want.status = ST_BAD_PROTO;
        end
        if (spelled_q.size() != 0) begin
          spelled = spelled_q.pop_front();
          if (spelled.given) want = spelled.v;
        end
        verdict_q.push_back(want);
        byte_pos = '0;
        run_sum  = SumStart;
      end else begin
        byte_pos = at + 5'd1;
      end
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no header pending");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          errors++;
        end
        if (res_ch.route !== want.route) begin
          $error("route: expected %0d, got %0d", want.route, res_ch.route);
          errors++;
        end
        if (res_ch.protocol !== want.protocol) begin
          $error("protocol: expected %0d, got %0d", want.protocol, res_ch.protocol);
          errors++;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.header_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < HeaderBytes; i++) push_byte(frame[i]);
  endtask

  // hold the sender until every result is out, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CfgVersion:  want_vl      = val;
      CfgFirstPr:  route0_proto = val;
      CfgSecondPr: route1_proto = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [7:0] vl, input logic [7:0] p1, input logic [7:0] p2);
    settle();
    write_reg(CfgVersion, vl);
    write_reg(CfgFirstPr, p1);
    write_reg(CfgSecondPr, p2);
    write_reg(CfgUnused, 8'($urandom));
  endtask

  task automatic seal_frame(input logic [7:0] vl, input logic [7:0] proto,
                            input logic [15:0] flip);
    logic [15:0] csum;
    frame[VersionPos] = vl;
    frame[ProtoPos]   = proto;
    csum = header_csum(frame) ^ flip;
    frame[CsumHiPos] = csum[15:8];
    frame[CsumLoPos] = csum[7:0];
  endtask

  task automatic make_frame(input frame_kind_e kind);
    logic [7:0] proto;
    for (int i = 0; i < HeaderBytes; i++) frame[i] = 8'($urandom);
    proto = $urandom_range(1) ? route0_proto : route1_proto;
    case (kind)
      FR_CLEAN:       seal_frame(want_vl, proto, 16'h0000);
      FR_BAD_VERSION: seal_frame(want_vl ^ 8'($urandom_range(255, 1)), proto, 16'h0000);
      FR_BAD_CSUM:    seal_frame(want_vl, proto, 16'($urandom_range(65535, 1)));
      FR_ODD_PROTO:   seal_frame(want_vl, 8'($urandom), 16'h0000);
      default: ;
    endcase
  endtask

  initial begin
    int          sent;
    int          phase;
    int          count;
    int          r;
    logic [7:0]  p1;
    frame_kind_e kind;
    spelled_t    entry;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgVersion;
    cfg_data            = 8'h00;
    byte_ch.valid       = 1'b0;
    byte_ch.header_byte = 8'h00;
    res_ch.ready        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (probes[k]) begin
      if (probes[k].cfg_vl != want_vl || probes[k].cfg_p1 != route0_proto ||
          probes[k].cfg_p2 != route1_proto)
        apply_config(probes[k].cfg_vl, probes[k].cfg_p1, probes[k].cfg_p2);
      for (int i = 0; i < HeaderBytes; i++) frame[i] = probes[k].fill;
      seal_frame(probes[k].vl, probes[k].proto, probes[k].flip);
      entry.given      = probes[k].known;
      entry.v.status   = probes[k].status;
      entry.v.route    = probes[k].route;
      entry.v.protocol = probes[k].proto;
      spelled_q.push_back(entry);
      send_frame();
    end

    sent  = $size(probes) * HeaderBytes;
    phase = 0;
    while (sent < 1250) begin
      case (phase)
        0: apply_config(8'h00, 8'h00, 8'hff);
        1: apply_config(8'hff, 8'hff, 8'h00);
        default: begin
          p1 = 8'($urandom);
          apply_config(($urandom_range(3) == 0) ? 8'h45 : 8'($urandom), p1,
                       ($urandom_range(5) == 0) ? p1 : 8'($urandom));
        end
      endcase
      gap_pct = (phase == 2) ? 0 : 26;
      count   = (phase == 2) ? 12 : $urandom_range(8, 3);
      for (int n = 0; n < count; n++) begin
        r = $urandom_range(99);
        if (r < 60) kind = FR_CLEAN;
        else if (r < 70) kind = FR_BAD_VERSION;
        else if (r < 80) kind = FR_BAD_CSUM;
        else if (r < 90) kind = FR_ODD_PROTO;
        else kind = FR_NOISE;
        make_frame(kind);
        send_frame();
        sent += HeaderBytes;
        if ((phase == 1 && n == 0) || $urandom_range(7) == 0) settle();
      end
      phase++;
    end

    settle();
    repeat (16) @(negedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
